@@ sv/pqe_pkg.sv @@
// ============================================================================
// pqe_pkg
// Shared constants, types and codes of the product-quantization encoder.
// ============================================================================
`timescale 1ns / 1ps

package pqe_pkg;

    // Sizing of the codebook and the data path.
    localparam int MAX_SUBSPACES = 16;
    localparam int MAX_CENTROIDS = 256;
    localparam int MAX_SUB_DIM   = 8;
    localparam int VALUE_WIDTH   = 16;

    localparam int SUB_W   = $clog2(MAX_SUBSPACES);
    localparam int CENT_W  = $clog2(MAX_CENTROIDS);
    localparam int COMP_W  = $clog2(MAX_SUB_DIM);
    localparam int BITS_W  = 4;
    localparam int MAX_CODE_BITS = 8;

    // One RAM row holds one component of one centroid; one RAM per component lane.
    localparam int STORE_ROWS = MAX_SUBSPACES * MAX_CENTROIDS;

    // Distance arithmetic: exact difference, exact square, exact sum.
    localparam int DIFF_W = VALUE_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = 2 * VALUE_WIDTH;
    localparam int PAIR_W = SQ_W + 1;
    localparam int DIST_W = SQ_W + COMP_W;
    localparam int NUM_PAIRS = MAX_SUB_DIM / 2;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (word address within the configuration port).
    typedef enum logic [1:0] {
        REG_NUM_SUBSPACES  = 2'd0,
        REG_CODE_BITS      = 2'd1,
        REG_SUB_DIM        = 2'd2,
        REG_CODEBOOK_VALID = 2'd3
    } reg_idx_t;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Kinds of jobs handed from front to back.
    typedef enum logic [1:0] {
        JOB_LOAD   = 2'd0,
        JOB_SEARCH = 2'd1,
        JOB_ERROR  = 2'd2
    } job_kind_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_ISSUE = 2'd1,
        BK_DRAIN = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [4:0] num_subspaces;
        logic [3:0] code_bits;
        logic [3:0] sub_dim;
        logic       codebook_valid;
    } cfg_t;

    typedef struct packed {
        job_kind_t                                    kind;
        logic [SUB_W-1:0]                             sub;
        logic [CENT_W-1:0]                            cent;
        logic [COMP_W-1:0]                            comp;
        logic [VALUE_WIDTH-1:0]                       value;
        logic [MAX_SUB_DIM-1:0][VALUE_WIDTH-1:0]      vec;
        logic [COMP_W-1:0]                            dim_m1;
        logic [CENT_W-1:0]                            ksub_m1;
        logic                                         last;
    } job_t;

    typedef struct packed {
        logic [CENT_W-1:0] code;
        logic [SUB_W-1:0]  subspace_out;
        logic              last;
        logic              error;
    } res_t;

endpackage

@@ sv/pqe_intf.sv @@
// ============================================================================
// pqe_in_if / pqe_out_if
// Valid/ready channels for input items and result items.
// ============================================================================
`timescale 1ns / 1ps

interface pqe_in_if import pqe_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [SUB_W-1:0]              subspace_sel;
    logic [CENT_W-1:0]             centroid_sel;
    logic [COMP_W-1:0]             component_sel;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, func, subspace_sel, centroid_sel, component_sel, value,
                    input ready);
    modport sink   (input valid, func, subspace_sel, centroid_sel, component_sel, value,
                    output ready);
endinterface

interface pqe_out_if import pqe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CENT_W-1:0] code;
    logic [SUB_W-1:0]  subspace_out;
    logic              last;
    logic              error;

    modport source (output valid, code, subspace_out, last, error, input ready);
    modport sink   (input valid, code, subspace_out, last, error, output ready);
endinterface

@@ sv/product_quantizer_encoder_unit.sv @@
// ============================================================================
// product_quantizer_encoder_unit
// Product-quantization encoder: loads a codebook of Q4.12 centroids and
// encodes query vectors into one nearest-centroid code per subspace.
// ============================================================================
//
//  Channel   Dir   Handshake            Carries
//  items     in    valid/ready          func, selectors, value
//  results   out   valid/ready          code, subspace_out, last, error
//  apb       in    psel/penable/pready  register writes and reads
//
//  A load item is queued and then written to the centroid RAMs by the back
//  end. A query component that completes a subspace starts a search over
//  2^code_bits centroids, one centroid per cycle, bounded by the single read
//  port of the per-lane centroid RAMs and the four-stage distance pipeline.
//  Reset clears control state only; the centroid store holds no value until
//  loaded. The two-entry job queue lets items keep arriving while a search
//  runs or a result waits on the output register.
//
`timescale 1ns / 1ps

module product_quantizer_encoder_unit import pqe_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    pqe_in_if.sink             items,
    pqe_out_if.source          results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_sel;
    logic     cfg_write;

    logic push, full, pop, empty, out_valid;
    job_t push_job, head;
    res_t out_res;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_NUM_SUBSPACES:  cfg_next.num_subspaces  = pwdata[4:0];
                REG_CODE_BITS:      cfg_next.code_bits      = pwdata[3:0];
                REG_SUB_DIM:        cfg_next.sub_dim        = pwdata[3:0];
                REG_CODEBOOK_VALID: cfg_next.codebook_valid = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_subspaces  <= 5'd8;
            cfg_reg.code_bits      <= 4'd8;
            cfg_reg.sub_dim        <= 4'd4;
            cfg_reg.codebook_valid <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_NUM_SUBSPACES:  prdata = PDATA_W'(cfg_reg.num_subspaces);
            REG_CODE_BITS:      prdata = PDATA_W'(cfg_reg.code_bits);
            REG_SUB_DIM:        prdata = PDATA_W'(cfg_reg.sub_dim);
            REG_CODEBOOK_VALID: prdata = PDATA_W'(cfg_reg.codebook_valid);
            default:            prdata = '0;
        endcase
    end

    // Front end: item intake and job building.
    pqe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .items    (items),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    // Job queue.
    pqe_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // Back end: centroid store and search.
    pqe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_ready (results.ready)
    );

    // Result channel.
    assign results.valid        = out_valid;
    assign results.code         = out_res.code;
    assign results.subspace_out = out_res.subspace_out;
    assign results.last         = out_res.last;
    assign results.error        = out_res.error;

endmodule

@@ sv/pqe_ram.sv @@
// ============================================================================
// pqe_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps

module pqe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/pqe_front.sv @@
// ============================================================================
// pqe_front
// Accepts items, gathers query components into sub-vectors and turns
// load items and sub-vectors into load, search or error jobs for the back end.
// ============================================================================
`timescale 1ns / 1ps

module pqe_front import pqe_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    pqe_in_if.sink        items,
    output logic          push,
    output job_t          push_job,
    input  logic          full
);

    logic [COMP_W-1:0]                       comp_cnt_reg, comp_cnt_next;
    logic [SUB_W-1:0]                        sub_cnt_reg, sub_cnt_next;
    logic                                    failed_reg, failed_next;
    logic [MAX_SUB_DIM-1:0][VALUE_WIDTH-1:0] qbuf_reg;
    logic [MAX_SUB_DIM-1:0][VALUE_WIDTH-1:0] qvec;

    logic [COMP_W-1:0] dim_m1;
    logic [SUB_W-1:0]  nsub_m1;
    logic [BITS_W-1:0] bits;
    logic [CENT_W-1:0] ksub_m1;

    logic accept, is_query, complete, final_sub, fail_now;
    logic [SUB_W-1:0] cur_sub;

    // Out-of-range register values clamp into the supported range.
    always_comb
    begin
        if (cfg.sub_dim == 4'd0)
            dim_m1 = '0;
        else if (cfg.sub_dim > 4'(MAX_SUB_DIM))
            dim_m1 = COMP_W'(MAX_SUB_DIM - 1);
        else
            dim_m1 = COMP_W'(cfg.sub_dim - 4'd1);

        if (cfg.num_subspaces == 5'd0)
            nsub_m1 = '0;
        else if (cfg.num_subspaces > 5'(MAX_SUBSPACES))
            nsub_m1 = SUB_W'(MAX_SUBSPACES - 1);
        else
            nsub_m1 = SUB_W'(cfg.num_subspaces - 5'd1);

        if (cfg.code_bits == 4'd0)
            bits = 4'd1;
        else if (cfg.code_bits > 4'(MAX_CODE_BITS))
            bits = 4'(MAX_CODE_BITS);
        else
            bits = cfg.code_bits;

        ksub_m1 = CENT_W'(((CENT_W+1)'(1) << bits) - (CENT_W+1)'(1));
    end

    // A new item is taken whenever the job queue has room.
    assign items.ready = !full;
    assign accept      = items.valid && items.ready;
    assign is_query    = (items.func == FUNC_QUERY);

    // Sub-vector with the incoming component merged in.
    always_comb
    begin
        for (int i = 0; i < MAX_SUB_DIM; i++)
        begin
            qvec[i] = (comp_cnt_reg == COMP_W'(i)) ? items.value : qbuf_reg[i];
        end
    end

    // Subspace bookkeeping.
    assign complete  = (comp_cnt_reg >= dim_m1);
    assign final_sub = (sub_cnt_reg >= nsub_m1);
    assign cur_sub   = final_sub ? nsub_m1 : sub_cnt_reg;
    assign fail_now  = failed_reg || !cfg.codebook_valid;

    always_comb
    begin
        comp_cnt_next = comp_cnt_reg;
        sub_cnt_next  = sub_cnt_reg;
        failed_next   = failed_reg;
        if (accept && is_query)
        begin
            if (complete)
            begin
                comp_cnt_next = '0;
                sub_cnt_next  = final_sub ? '0 : cur_sub + SUB_W'(1);
                failed_next   = final_sub ? 1'b0 : fail_now;
            end
            else
            begin
                comp_cnt_next = comp_cnt_reg + COMP_W'(1);
            end
        end
    end

    // Job generation.
    always_comb
    begin
        push_job         = '0;
        push_job.vec     = qvec;
        push_job.dim_m1  = dim_m1;
        push_job.ksub_m1 = ksub_m1;
        push_job.value   = items.value;
        push_job.last    = final_sub;
        push             = 1'b0;
        if (!is_query)
        begin
            push_job.kind = JOB_LOAD;
            push_job.sub  = items.subspace_sel;
            push_job.cent = items.centroid_sel;
            push_job.comp = items.component_sel;
            push          = accept;
        end
        else
        begin
            push_job.kind = fail_now ? JOB_ERROR : JOB_SEARCH;
            push_job.sub  = cur_sub;
            push          = accept && complete && (!fail_now || final_sub);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_cnt_reg <= '0;
            sub_cnt_reg  <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            comp_cnt_reg <= comp_cnt_next;
            sub_cnt_reg  <= sub_cnt_next;
            failed_reg   <= failed_next;
        end
    end

    // Query component buffer.
    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            qbuf_reg <= qvec;
        end
    end

endmodule

@@ sv/pqe_fifo.sv @@
// ============================================================================
// pqe_fifo
// Short job queue that decouples the front end from the back end.
// ============================================================================
`timescale 1ns / 1ps

module pqe_fifo import pqe_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < Q_CNT_W'(QUEUE_DEPTH)))
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue read while empty");
`endif

endmodule

@@ sv/pqe_back.sv @@
// ============================================================================
// pqe_back
// Executes jobs: writes centroid components, runs the nearest-centroid search
// over one centroid per cycle, and holds the result for the output channel.
// ============================================================================
`timescale 1ns / 1ps

module pqe_back import pqe_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  job_t head,
    input  logic empty,
    output logic pop,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [CENT_W-1:0] k_reg, k_next;

    logic slot_free, head_is_load, pop_search, pop_error, ram_re, issue_last;

    logic [VALUE_WIDTH-1:0] rd_data [MAX_SUB_DIM];

    // Pipeline stage control.
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic              s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [CENT_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;

    // Pipeline stage data.
    logic signed [DIFF_W-1:0] diff [MAX_SUB_DIM];
    logic signed [PROD_W-1:0] prod [MAX_SUB_DIM];
    logic [SQ_W-1:0]          sq_reg [MAX_SUB_DIM];
    logic [PAIR_W-1:0]        pair_reg [NUM_PAIRS];
    logic [DIST_W-1:0]        dist_sum;
    logic [DIST_W-1:0]        dist_reg;

    logic [DIST_W-1:0] best_dist_reg;
    logic [CENT_W-1:0] best_idx_reg;
    logic              better, out_load;
    res_t              out_res_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    assign slot_free    = !out_valid_reg || out_ready;
    assign head_is_load = (head.kind == JOB_LOAD);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty && !head_is_load && slot_free && head.kind == JOB_SEARCH)
                    state_next = BK_ISSUE;
            end
            BK_ISSUE:
            begin
                if (k_reg == job_reg.ksub_m1)
                    state_next = BK_DRAIN;
            end
            BK_DRAIN:
            begin
                if (s4_valid_reg && s4_last_reg)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop        = 1'b0;
        ram_re     = 1'b0;
        issue_last = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !empty && (head_is_load || slot_free);
            end
            BK_ISSUE:
            begin
                ram_re     = 1'b1;
                issue_last = (k_reg == job_reg.ksub_m1);
            end
            BK_DRAIN:
            begin
                pop = 1'b0;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign pop_search = pop && (head.kind == JOB_SEARCH);
    assign pop_error  = pop && (head.kind == JOB_ERROR);

    // Centroid index counter.
    always_comb
    begin
        k_next = k_reg;
        if (pop_search)
            k_next = '0;
        else if (ram_re)
            k_next = k_reg + CENT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Current search job.
    always_ff @(posedge clk)
    begin
        if (pop_search)
        begin
            job_reg <= head;
        end
    end

    // Centroid store: one RAM per component lane.
    for (genvar g = 0; g < MAX_SUB_DIM; g++)
    begin : g_lane
        pqe_ram #(
            .WIDTH (VALUE_WIDTH),
            .DEPTH (STORE_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (pop && head_is_load && (head.comp == COMP_W'(g))),
            .waddr ({head.sub, head.cent}),
            .wdata (head.value),
            .re    (ram_re),
            .raddr ({job_reg.sub, k_reg}),
            .rdata (rd_data[g])
        );
    end

    // Per-lane difference and square; lanes past the sub-vector give zero.
    always_comb
    begin
        for (int i = 0; i < MAX_SUB_DIM; i++)
        begin
            diff[i] = $signed({job_reg.vec[i][VALUE_WIDTH-1], job_reg.vec[i]})
                    - $signed({rd_data[i][VALUE_WIDTH-1], rd_data[i]});
            prod[i] = diff[i] * diff[i];
        end
    end

    // Final sum of the pair sums.
    always_comb
    begin
        dist_sum = '0;
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            dist_sum = dist_sum + DIST_W'(pair_reg[j]);
        end
    end

    // Search pipeline: read, square, pair add, total.
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= k_reg;
        s1_last_reg <= issue_last;
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_last_reg <= s2_last_reg;
        s4_idx_reg  <= s3_idx_reg;
        s4_last_reg <= s3_last_reg;
        for (int i = 0; i < MAX_SUB_DIM; i++)
        begin
            sq_reg[i] <= (COMP_W'(i) <= job_reg.dim_m1) ? prod[i][SQ_W-1:0] : '0;
        end
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            pair_reg[j] <= PAIR_W'(sq_reg[2*j]) + PAIR_W'(sq_reg[2*j+1]);
        end
        dist_reg <= dist_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ram_re;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Running minimum; a strict compare keeps the lowest index on a tie.
    assign better = (s4_idx_reg == '0) || (dist_reg < best_dist_reg);

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && better)
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= s4_idx_reg;
        end
    end

    // Result register.
    assign out_load = pop_error || (s4_valid_reg && s4_last_reg);

    always_comb
    begin
        out_res_next = out_res_reg;
        if (pop_error)
        begin
            out_res_next.code         = '0;
            out_res_next.subspace_out = head.sub;
            out_res_next.last         = 1'b1;
            out_res_next.error        = 1'b1;
        end
        else if (s4_valid_reg && s4_last_reg)
        begin
            out_res_next.code         = better ? s4_idx_reg : best_idx_reg;
            out_res_next.subspace_out = job_reg.sub;
            out_res_next.last         = job_reg.last;
            out_res_next.error        = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef NO_ASSERTIONS
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result written over an untaken result");
    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !pop)
        else $error("job taken while a search is running");
    a_search_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_last_reg) |-> (state_reg == BK_DRAIN))
        else $error("search finished outside the drain state");
`endif

endmodule

@@ sim/testbench.sv @@
// ============================================================================
// testbench
// Self-checking bench for the product-quantization encoder. A driver feeds
// load and query items from a backlog. A monitor compares every result with
// a bit-exact nearest-centroid predictor. The run goes through several
// register settings, the extremes among them, and idles both channels.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import pqe_pkg::*;

    // Pause before a register write: two back-to-back full searches.
    localparam int SETTLE_CYCLES = 2 * (MAX_CENTROIDS + 5) + 40;
    // Allow far more time than the slowest correct run needs.
    localparam longint TIMEOUT_NS = 100_000_000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 90;
    localparam int STORE_DEPTH = STORE_ROWS * MAX_SUB_DIM;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 2 ** (VALUE_WIDTH - 1) - 1;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = -(2 ** (VALUE_WIDTH - 1));

    // Register settings per phase; zero and over-range values test clamping.
    localparam int PH_SUBSPACES [NUM_PHASES] = '{4, 16, 1, 1, 0, 31, 2, 3, 5, 1};
    localparam int PH_CODE_BITS [NUM_PHASES] = '{3, 1, 8, 1, 0, 2, 1, 2, 4, 15};
    localparam int PH_SUB_DIM   [NUM_PHASES] = '{3, 1, 1, 8, 0, 2, 15, 4, 2, 1};
    localparam int PH_VALID     [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 1, 0, 1, 1};

    typedef struct {
        logic                          func;
        logic [SUB_W-1:0]              sub;
        logic [CENT_W-1:0]             cent;
        logic [COMP_W-1:0]             comp;
        logic signed [VALUE_WIDTH-1:0] value;
    } pq_item_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    pqe_in_if  items_if ();
    pqe_out_if results_if ();

    product_quantizer_encoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus backlog and codes still owed by the block.
    pq_item_t item_backlog [$];
    res_t     expected_codes [$];
    pq_item_t head_item;
    res_t     got_code;
    res_t     want_code;

    // Mirror of the block: codebook, query buffer, counters and registers.
    logic signed [VALUE_WIDTH-1:0] codebook_mirror [STORE_DEPTH];
    bit                            cb_written [STORE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] query_mirror [MAX_SUB_DIM];
    int   comp_count = 0;
    int   sub_count = 0;
    bit   vector_failed = 1'b0;
    logic [4:0] cfg_subspaces = 5'd8;
    logic [3:0] cfg_code_bits = 4'd8;
    logic [3:0] cfg_sub_dim = 4'd4;
    logic       cfg_valid = 1'b0;

    int accepted_total = 0;
    int loads_seen = 0;
    int queries_seen = 0;
    int results_checked = 0;
    int error_results = 0;
    int cfg_writes = 0;
    int error_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_reg(int v, int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int eff_subspaces();
        return clamp_reg(cfg_subspaces, MAX_SUBSPACES);
    endfunction

    function automatic int eff_sub_dim();
        return clamp_reg(cfg_sub_dim, MAX_SUB_DIM);
    endfunction

    function automatic int eff_centroids();
        int k;
        k = 1 << clamp_reg(cfg_code_bits, MAX_CODE_BITS);
        return (k > MAX_CENTROIDS) ? MAX_CENTROIDS : k;
    endfunction

    // Idle pattern rotates with progress: none, sender, receiver, both.
    function automatic int traffic_mode();
        return (accepted_total / 37) % 4;
    endfunction

    function automatic bit sender_pauses();
        case (traffic_mode())
            1: return $urandom_range(99) < 73;
            3: return $urandom_range(99) < 31;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (traffic_mode())
            2: return $urandom_range(99) < 73;
            3: return $urandom_range(99) < 31;
            default: return 1'b0;
        endcase
    endfunction

    // Values lean toward extremes and a narrow band so that ties occur.
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return VALUE_WIDTH'($urandom_range(16) - 8);
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic string fmt_code(res_t r);
        return $sformatf("code=%0d sub=%0d last=%0b error=%0b",
                         r.code, r.subspace_out, r.last, r.error);
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic push_load(logic [SUB_W-1:0] s, logic [CENT_W-1:0] c,
                             logic [COMP_W-1:0] p, logic signed [VALUE_WIDTH-1:0] v);
        pq_item_t it;
        it.func  = FUNC_LOAD;
        it.sub   = s;
        it.cent  = c;
        it.comp  = p;
        it.value = v;
        cb_written[(s * MAX_CENTROIDS + c) * MAX_SUB_DIM + p] = 1'b1;
        item_backlog.push_back(it);
    endtask

    // Selectors of a query are don't-care; they carry random bits.
    task automatic push_query(logic signed [VALUE_WIDTH-1:0] v);
        pq_item_t it;
        it.func  = FUNC_QUERY;
        it.sub   = SUB_W'($urandom);
        it.cent  = CENT_W'($urandom);
        it.comp  = COMP_W'($urandom);
        it.value = v;
        item_backlog.push_back(it);
    endtask

    task automatic wait_idle();
        while (item_backlog.size() != 0 || items_if.valid || expected_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write once the block is idle: setup cycle, then access cycle.
    task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUM_SUBSPACES:  cfg_subspaces = val[4:0];
            REG_CODE_BITS:      cfg_code_bits = val[3:0];
            REG_SUB_DIM:        cfg_sub_dim   = val[3:0];
            REG_CODEBOOK_VALID: cfg_valid     = val[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Predictor: apply one accepted item and queue the code it yields.
    function automatic void encode_step(logic func, logic [SUB_W-1:0] s,
                                        logic [CENT_W-1:0] c, logic [COMP_W-1:0] p,
                                        logic signed [VALUE_WIDTH-1:0] v);
        int nsub;
        int dim;
        int ksub;
        int sub;
        int best;
        int base;
        bit final_sub;
        longint diff;
        longint unsigned cand_dist;
        longint unsigned best_dist;
        res_t r;
        if (func == FUNC_LOAD)
        begin
            codebook_mirror[(s * MAX_CENTROIDS + c) * MAX_SUB_DIM + p] = v;
            loads_seen++;
            return;
        end
        queries_seen++;
        nsub = eff_subspaces();
        dim  = eff_sub_dim();
        ksub = eff_centroids();

        query_mirror[comp_count] = v;
        if (comp_count + 1 < dim)
        begin
            comp_count++;
            return;
        end
        comp_count = 0;

        // A count left beyond a lowered limit snaps to the final subspace.
        if (sub_count >= nsub)
            sub_count = nsub - 1;
        sub = sub_count;
        final_sub = (sub + 1 >= nsub);
        if (!cfg_valid)
            vector_failed = 1'b1;

        if (vector_failed)
        begin
            if (final_sub)
            begin
                r.code         = '0;
                r.subspace_out = SUB_W'(sub);
                r.last         = 1'b1;
                r.error        = 1'b1;
                expected_codes.push_back(r);
            end
        end
        else
        begin
            // Exhaustive search; strict less-than keeps the lowest index on a tie.
            best = 0;
            best_dist = 0;
            for (int k = 0; k < ksub; k++)
            begin
                base = (sub * MAX_CENTROIDS + k) * MAX_SUB_DIM;
                cand_dist = 0;
                for (int i = 0; i < dim; i++)
                begin
                    diff = longint'(query_mirror[i]) - longint'(codebook_mirror[base + i]);
                    cand_dist += longint'(diff * diff);
                end
                if (k == 0 || cand_dist < best_dist)
                begin
                    best_dist = cand_dist;
                    best = k;
                end
            end
            r.code         = CENT_W'(best);
            r.subspace_out = SUB_W'(sub);
            r.last         = final_sub;
            r.error        = 1'b0;
            expected_codes.push_back(r);
        end

        if (final_sub)
        begin
            sub_count = 0;
            vector_failed = 1'b0;
        end
        else
            sub_count = sub + 1;
    endfunction

    // Driver: hold an item until its transfer, then take the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            items_if.valid <= 1'b0;
        else
        begin
            if (items_if.valid && items_if.ready)
            begin
                encode_step(items_if.func, items_if.subspace_sel, items_if.centroid_sel,
                            items_if.component_sel, items_if.value);
                accepted_total <= accepted_total + 1;
            end
            if (!items_if.valid || items_if.ready)
            begin
                if (item_backlog.size() != 0 && !sender_pauses())
                begin
                    head_item = item_backlog.pop_front();
                    items_if.valid         <= 1'b1;
                    items_if.func          <= head_item.func;
                    items_if.subspace_sel  <= head_item.sub;
                    items_if.centroid_sel  <= head_item.cent;
                    items_if.component_sel <= head_item.comp;
                    items_if.value         <= head_item.value;
                end
                else
                    items_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                got_code.code         = results_if.code;
                got_code.subspace_out = results_if.subspace_out;
                got_code.last         = results_if.last;
                got_code.error        = results_if.error;
                results_checked++;
                if (got_code.error === 1'b1)
                    error_results++;
                if (expected_codes.size() == 0)
                    log_error($sformatf("unexpected result %s", fmt_code(got_code)));
                else
                begin
                    want_code = expected_codes.pop_front();
                    if (got_code !== want_code)
                        log_error($sformatf("expected %s, got %s",
                                            fmt_code(want_code), fmt_code(got_code)));
                end
            end
            results_if.ready <= !receiver_stalls();
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[%0t] Timeout with %0d codes outstanding", $time, expected_codes.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int nsub;
        int dim;
        int ksub;
        int sent;
        int roll;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_if.valid = 1'b0;
        items_if.func = FUNC_LOAD;
        items_if.subspace_sel = '0;
        items_if.centroid_sel = '0;
        items_if.component_sel = '0;
        items_if.value = '0;
        results_if.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two subspaces, two centroids, one component each.
        reg_write(REG_NUM_SUBSPACES, 2);
        reg_write(REG_CODE_BITS, 1);
        reg_write(REG_SUB_DIM, 1);
        reg_write(REG_CODEBOOK_VALID, 0);

        // Encoding with no valid codebook ends in one error result.
        push_query(VAL_MAX);
        push_query(VAL_MIN);

        // Extreme centroids in subspace 0, identical centroids in subspace 1.
        push_load(0, 0, 0, VAL_MAX);
        push_load(0, 1, 0, VAL_MIN);
        push_load(1, 0, 0, 5);
        push_load(1, 1, 0, 5);
        reg_write(REG_CODEBOOK_VALID, 1);
        push_query(VAL_MAX);
        push_query(VAL_MIN);
        push_query(VAL_MIN);
        push_query(1);

        // Codebook turned off in mid-vector, then back on in mid-vector.
        push_query(0);
        reg_write(REG_CODEBOOK_VALID, 0);
        push_query(0);
        push_query(7);
        reg_write(REG_CODEBOOK_VALID, 1);
        push_query(7);

        // Sub-vector length and subspace count lowered in mid-vector.
        push_load(0, 0, 1, -1);
        push_load(0, 1, 1, 1);
        push_load(1, 0, 1, 0);
        push_load(1, 1, 1, 0);
        reg_write(REG_SUB_DIM, 2);
        push_query(100);
        reg_write(REG_SUB_DIM, 1);
        push_query(-100);
        reg_write(REG_NUM_SUBSPACES, 1);
        push_query(-5);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            reg_write(REG_NUM_SUBSPACES, PH_SUBSPACES[ph]);
            reg_write(REG_CODE_BITS, PH_CODE_BITS[ph]);
            reg_write(REG_SUB_DIM, PH_SUB_DIM[ph]);
            reg_write(REG_CODEBOOK_VALID, PH_VALID[ph]);
            nsub = eff_subspaces();
            dim  = eff_sub_dim();
            ksub = eff_centroids();

            // Load every centroid entry this setting can read and that is still empty.
            for (int s = 0; s < nsub; s++)
                for (int c = 0; c < ksub; c++)
                    for (int p = 0; p < dim; p++)
                        if (!cb_written[(s * MAX_CENTROIDS + c) * MAX_SUB_DIM + p])
                            push_load(s, c, p, pick_value());

            // Mostly whole vectors; some are cut short or have loads mixed in.
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                for (int j = 0; j < nsub * dim && sent < PHASE_ITEMS; j++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 3)
                        break;
                    if (roll < 7)
                    begin
                        push_load(SUB_W'($urandom), CENT_W'($urandom), COMP_W'($urandom),
                                  pick_value());
                        sent++;
                    end
                    else if (roll < 12)
                    begin
                        push_load(SUB_W'($urandom_range(nsub - 1)),
                                  CENT_W'($urandom_range(ksub - 1)),
                                  COMP_W'($urandom_range(dim - 1)), pick_value());
                        sent++;
                    end
                    push_query(pick_value());
                    sent++;
                end
            end
        end

        wait_idle();
        if (expected_codes.size() != 0)
            log_error($sformatf("%0d expected codes never arrived", expected_codes.size()));
        $display("Run covered %0d loads and %0d query components over %0d register writes",
                 loads_seen, queries_seen, cfg_writes);
        $display("Checked %0d results, %0d of them error results; %0d failures",
                 results_checked, error_results, error_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pqe_pkg.sv
sv/pqe_intf.sv
sv/pqe_ram.sv
sv/pqe_front.sv
sv/pqe_fifo.sv
sv/pqe_back.sv
sv/product_quantizer_encoder_unit.sv
sim/testbench.sv
